### sv/dbdf_pkg.sv
package dbdf_pkg;

    localparam int MAX_KEPT_DEF = 64;

    localparam int X_W      = 12;
    localparam int SIZE_W   = 13;
    localparam int AREA_W   = 2 * SIZE_W;
    localparam int RATIO_W  = 17;
    localparam int RATIO_FRAC = 16;
    localparam int PROD_W   = RATIO_W + AREA_W;
    localparam int SCORE_W  = 16;
    localparam int FRAME_W  = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_H   = 2'd3;

    localparam logic signed [SCORE_W-1:0] SCORE_THR_RST = 16'sd0;
    localparam logic [RATIO_W-1:0]        RATIO_THR_RST = 17'd32768;
    localparam logic [SIZE_W-1:0]         FRAME_W_RST   = 13'd4096;
    localparam logic [SIZE_W-1:0]         FRAME_H_RST   = 13'd4096;

    localparam int GROW_SIDE  = 20;
    localparam int GROW_TOTAL = 40;

    typedef struct packed {
        logic [X_W-1:0]    x;
        logic [X_W-1:0]    y;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } t_box;

    // A request travelling down the cell row. The overlap products of one cell
    // are judged by the next cell, so multiply and compare sit in different cycles.
    typedef struct packed {
        logic              valid;
        t_box              box;
        logic [AREA_W-1:0] area;
        logic              dup;
        logic              pend;
        logic [AREA_W-1:0] inter;
        logic [PROD_W-1:0] thr_small;
    } t_query;

    function automatic logic dup_hit(input t_query q);
        return q.pend && (PROD_W'({q.inter, {RATIO_FRAC{1'b0}}}) > q.thr_small);
    endfunction

endpackage

### sv/dbdf_cell.sv
module dbdf_cell
    import dbdf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [RATIO_W-1:0] i_ratio_thr,
    input  logic               i_enable,
    input  logic               i_wr,
    input  t_box               i_wr_box,
    input  logic [AREA_W-1:0]  i_wr_area,
    input  t_query             i_q,
    output t_query             o_q
);

    t_box              r_box;
    logic [AREA_W-1:0] r_area;
    t_query            r_q;
    t_query            n_q;

    logic [X_W-1:0]    x0;
    logic [X_W-1:0]    y0;
    logic [X_W+1:0]    qx_end;
    logic [X_W+1:0]    sx_end;
    logic [X_W+1:0]    qy_end;
    logic [X_W+1:0]    sy_end;
    logic [X_W+1:0]    x1;
    logic [X_W+1:0]    y1;
    logic [SIZE_W-1:0] ow;
    logic [SIZE_W-1:0] oh;
    logic [AREA_W-1:0] smaller;
    logic              identical;

    always_comb begin
        x0 = (i_q.box.x > r_box.x) ? i_q.box.x : r_box.x;
        y0 = (i_q.box.y > r_box.y) ? i_q.box.y : r_box.y;
        qx_end = (X_W+2)'(i_q.box.x) + (X_W+2)'(i_q.box.w);
        sx_end = (X_W+2)'(r_box.x) + (X_W+2)'(r_box.w);
        qy_end = (X_W+2)'(i_q.box.y) + (X_W+2)'(i_q.box.h);
        sy_end = (X_W+2)'(r_box.y) + (X_W+2)'(r_box.h);
        x1 = (qx_end < sx_end) ? qx_end : sx_end;
        y1 = (qy_end < sy_end) ? qy_end : sy_end;
        // The overlap never exceeds either width, so it fits the size field.
        ow = (x1 > (X_W+2)'(x0)) ? SIZE_W'(x1 - (X_W+2)'(x0)) : '0;
        oh = (y1 > (X_W+2)'(y0)) ? SIZE_W'(y1 - (X_W+2)'(y0)) : '0;
        smaller = (i_q.area < r_area) ? i_q.area : r_area;
        identical = (i_q.box == r_box);

        n_q           = i_q;
        n_q.dup       = i_q.dup | dup_hit(i_q);
        n_q.pend      = i_q.valid & i_enable & ~identical;
        n_q.inter     = AREA_W'(ow) * AREA_W'(oh);
        n_q.thr_small = PROD_W'(i_ratio_thr) * PROD_W'(smaller);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else begin
            r_q.valid <= n_q.valid;
        end
        r_q.box       <= n_q.box;
        r_q.area      <= n_q.area;
        r_q.dup       <= n_q.dup;
        r_q.pend      <= n_q.pend;
        r_q.inter     <= n_q.inter;
        r_q.thr_small <= n_q.thr_small;
        if (i_wr) begin
            r_box  <= i_wr_box;
            r_area <= i_wr_area;
        end
    end

    assign o_q = r_q;

endmodule

### sv/detection_box_duplicate_filter.sv
// Greedy duplicate filter for scored detection boxes. A box is kept when its
// score is above the score threshold and its overlap with no box kept earlier
// in the frame, taken over the smaller of the two areas, exceeds the ratio
// threshold; boxes identical to a kept box never count as duplicates. Kept
// boxes are stored in a row of MAX_KEPT cells, one box per cell, and each
// request walks the row one cell per clock. One request is handled at a time:
// a new one is accepted only after the last has walked the whole row and its
// result has been registered at the output. The result of a kept box is the box grown
// by 20 pixels on each side and clipped to the frame; when all cells are taken
// the box is still reported, with store_full set. first_in_frame empties the
// store. Every request gives exactly one result; a rejected box gives all zeros.
module detection_box_duplicate_filter
    import dbdf_pkg::*;
#(
    parameter int MAX_KEPT = MAX_KEPT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,

    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_first_in_frame,
    input  logic [X_W-1:0]            i_box_x,
    input  logic [X_W-1:0]            i_box_y,
    input  logic [SIZE_W-1:0]         i_box_width,
    input  logic [SIZE_W-1:0]         i_box_height,
    input  logic signed [SCORE_W-1:0] i_score,
    input  logic [FRAME_W-1:0]        i_frame_number,

    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_kept,
    output logic [X_W-1:0]            o_out_x,
    output logic [X_W-1:0]            o_out_y,
    output logic [SIZE_W-1:0]         o_out_width,
    output logic [SIZE_W-1:0]         o_out_height,
    output logic signed [SCORE_W-1:0] o_out_score,
    output logic [FRAME_W-1:0]        o_out_frame_number,
    output logic                      o_store_full
);

    localparam int CNT_W = $clog2(MAX_KEPT + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                r_state;
    logic [CNT_W-1:0]          r_count;
    t_query                    r_head;
    logic                      r_pass;
    logic                      r_dup;
    logic signed [SCORE_W-1:0] r_score;
    logic [FRAME_W-1:0]        r_frame;

    logic signed [SCORE_W-1:0] r_score_thr;
    logic [RATIO_W-1:0]        r_ratio_thr;
    logic [SIZE_W-1:0]         r_frame_w;
    logic [SIZE_W-1:0]         r_frame_h;

    logic                      r_o_valid;
    logic                      r_kept;
    logic [X_W-1:0]            r_out_x;
    logic [X_W-1:0]            r_out_y;
    logic [SIZE_W-1:0]         r_out_w;
    logic [SIZE_W-1:0]         r_out_h;
    logic signed [SCORE_W-1:0] r_out_score;
    logic [FRAME_W-1:0]        r_out_frame;
    logic                      r_full;

    t_query                    w_chain [MAX_KEPT+1];
    logic [MAX_KEPT:0]         w_chain_valid;
    t_query                    w_tail;
    logic                      w_tail_dup;
    logic                      w_in_acc;
    logic                      w_fin;
    logic                      w_keep;
    logic                      w_room;
    logic                      w_store;

    logic [X_W-1:0]            w_gx;
    logic [X_W-1:0]            w_gy;
    logic [X_W+2:0]            w_gw0;
    logic [X_W+2:0]            w_gh0;
    logic [X_W+2:0]            w_dw;
    logic [X_W+2:0]            w_dh;
    logic [SIZE_W-1:0]         w_gw;
    logic [SIZE_W-1:0]         w_gh;

    assign o_ready  = (r_state == S_IDLE);
    assign w_in_acc = i_valid & o_ready;

    assign w_chain[0] = r_head;

    genvar g;
    generate
        for (g = 0; g < MAX_KEPT; g++) begin : g_cell
            dbdf_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ratio_thr (r_ratio_thr),
                .i_enable    (CNT_W'(g) < r_count),
                .i_wr        (w_store && (r_count == CNT_W'(g))),
                .i_wr_box    (r_head.box),
                .i_wr_area   (r_head.area),
                .i_q         (w_chain[g]),
                .o_q         (w_chain[g+1])
            );
        end
        for (g = 0; g <= MAX_KEPT; g++) begin : g_valid
            assign w_chain_valid[g] = w_chain[g].valid;
        end
    endgenerate

    assign w_tail     = w_chain[MAX_KEPT];
    assign w_tail_dup = w_tail.dup | dup_hit(w_tail);

    assign w_fin   = (r_state == S_DONE) && (!r_o_valid || i_ready);
    assign w_keep  = r_pass & ~r_dup;
    assign w_room  = (r_count < CNT_W'(MAX_KEPT));
    assign w_store = w_fin & w_keep & w_room;

    // Grow by the margin, clamp the corner at zero, then cut at the frame edge.
    always_comb begin
        w_gx  = (r_head.box.x >= X_W'(GROW_SIDE)) ? (r_head.box.x - X_W'(GROW_SIDE)) : '0;
        w_gy  = (r_head.box.y >= X_W'(GROW_SIDE)) ? (r_head.box.y - X_W'(GROW_SIDE)) : '0;
        w_gw0 = (X_W+3)'(r_head.box.w) + (X_W+3)'(GROW_TOTAL);
        w_gh0 = (X_W+3)'(r_head.box.h) + (X_W+3)'(GROW_TOTAL);
        w_dw  = (X_W+3)'(r_frame_w) - (X_W+3)'(w_gx);
        w_dh  = (X_W+3)'(r_frame_h) - (X_W+3)'(w_gy);
        if (((X_W+3)'(w_gx) + w_gw0) > (X_W+3)'(r_frame_w)) begin
            w_gw = w_dw[X_W+2] ? '0 : w_dw[SIZE_W-1:0];
        end else begin
            w_gw = w_gw0[SIZE_W-1:0];
        end
        if (((X_W+3)'(w_gy) + w_gh0) > (X_W+3)'(r_frame_h)) begin
            w_gh = w_dh[X_W+2] ? '0 : w_dh[SIZE_W-1:0];
        end else begin
            w_gh = w_gh0[SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_o_valid    <= 1'b0;
            r_score_thr  <= SCORE_THR_RST;
            r_ratio_thr  <= RATIO_THR_RST;
            r_frame_w    <= FRAME_W_RST;
            r_frame_h    <= FRAME_H_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCORE_THR: r_score_thr <= signed'(i_cfg_data[SCORE_W-1:0]);
                    CFG_RATIO_THR: r_ratio_thr <= i_cfg_data[RATIO_W-1:0];
                    CFG_FRAME_W:   r_frame_w   <= i_cfg_data[SIZE_W-1:0];
                    CFG_FRAME_H:   r_frame_h   <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_RUN;
                        if (i_first_in_frame) begin
                            r_count <= '0;
                        end
                    end
                end
                S_RUN: begin
                    if (w_tail.valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_fin) begin
                        r_state <= S_IDLE;
                        if (w_store) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_fin) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else begin
            r_head.valid <= w_in_acc;
        end
        if (w_in_acc) begin
            r_head.box   <= '{x: i_box_x, y: i_box_y, w: i_box_width, h: i_box_height};
            r_head.area  <= AREA_W'(i_box_width) * AREA_W'(i_box_height);
            r_head.dup   <= 1'b0;
            r_head.pend  <= 1'b0;
            r_head.inter <= '0;
            r_head.thr_small <= '0;
            r_pass       <= (i_score > r_score_thr);
            r_score      <= i_score;
            r_frame      <= i_frame_number;
        end
        if (w_tail.valid) begin
            r_dup <= w_tail_dup;
        end
        if (w_fin) begin
            r_kept      <= w_keep;
            r_out_x     <= w_keep ? w_gx : '0;
            r_out_y     <= w_keep ? w_gy : '0;
            r_out_w     <= w_keep ? w_gw : '0;
            r_out_h     <= w_keep ? w_gh : '0;
            r_out_score <= w_keep ? r_score : '0;
            r_out_frame <= w_keep ? r_frame : '0;
            r_full      <= w_keep & ~w_room;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_kept             = r_kept;
    assign o_out_x            = r_out_x;
    assign o_out_y            = r_out_y;
    assign o_out_width        = r_out_w;
    assign o_out_height       = r_out_h;
    assign o_out_score        = r_out_score;
    assign o_out_frame_number = r_out_frame;
    assign o_store_full       = r_full;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEPT))
        else $error("kept count exceeds the number of cells");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_chain_valid) <= 1)
        else $error("more than one request in the cell row");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised without a finished request");

    a_busy_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_chain_valid) |-> !o_ready)
        else $error("new request taken while the row is busy");
`endif

endmodule
